/* src/jbhp_pkg.sv */
// Shared types and constants for the JPEG baseline header parser.
`default_nettype none
package jbhp_pkg;

   localparam int POS_BITS   = 24;
   localparam int LEN_BITS   = 24;
   localparam int DIM_BITS   = 16;
   localparam int STAT_BITS  = 3;
   localparam int SUM_BITS   = ((POS_BITS > LEN_BITS) ? POS_BITS : LEN_BITS) + 1;
   localparam int RSP_BITS   = STAT_BITS + 2 * DIM_BITS;
   localparam int RSP_TDATA_BITS = ((RSP_BITS + 7) / 8) * 8;

   // verdict codes
   localparam logic [STAT_BITS-1:0] ST_OK        = 3'd0;
   localparam logic [STAT_BITS-1:0] ST_NO_SOI    = 3'd1;
   localparam logic [STAT_BITS-1:0] ST_END_SCAN  = 3'd2;
   localparam logic [STAT_BITS-1:0] ST_BAD_LEN   = 3'd3;
   localparam logic [STAT_BITS-1:0] ST_UNSUP     = 3'd4;
   localparam logic [STAT_BITS-1:0] ST_BAD_SIZE  = 3'd5;
   localparam logic [STAT_BITS-1:0] ST_DATA_END  = 3'd6;

   // register indexes
   localparam logic REG_TOTAL_LENGTH  = 1'b0;
   localparam logic REG_MAX_DIMENSION = 1'b1;

   localparam logic [LEN_BITS-1:0] TOTAL_LENGTH_RST  = '0;
   localparam logic [DIM_BITS-1:0] MAX_DIMENSION_RST = 16'd4096;

   // marker bytes
   localparam logic [7:0] MK_FILL  = 8'hFF;
   localparam logic [7:0] MK_SOI   = 8'hD8;
   localparam logic [7:0] MK_EOI   = 8'hD9;
   localparam logic [7:0] MK_SOS   = 8'hDA;
   localparam logic [7:0] MK_TEM   = 8'h01;
   localparam logic [7:0] MK_RST0  = 8'hD0;
   localparam logic [7:0] MK_RST7  = 8'hD7;
   localparam logic [7:0] MK_SOF0  = 8'hC0;
   localparam logic [7:0] MK_SOF15 = 8'hCF;
   localparam logic [7:0] MK_DHT   = 8'hC4;
   localparam logic [7:0] MK_JPG   = 8'hC8;
   localparam logic [7:0] MK_DAC   = 8'hCC;

   // frame header values accepted for a baseline frame
   localparam logic [7:0] PRECISION   = 8'd8;
   localparam logic [7:0] COMPS_GRAY  = 8'd1;
   localparam logic [7:0] COMPS_COLOR = 8'd3;

   typedef struct packed {
      logic [LEN_BITS-1:0] total_length;
      logic [DIM_BITS-1:0] max_dimension;
   } cfg_type;

   typedef struct packed {
      logic [STAT_BITS-1:0] status;
      logic [DIM_BITS-1:0]  image_width;
      logic [DIM_BITS-1:0]  image_height;
   } rsp_item_type;

   typedef struct packed {
      logic         valid;
      rsp_item_type item;
   } verdict_type;

endpackage
`default_nettype wire

/* src/jbhp_csr.sv */
// Configuration registers behind the APB-style port.
`default_nettype none
module jbhp_csr
   import jbhp_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_psel,
   input  wire logic        csr_penable,
   input  wire logic        csr_pwrite,
   input  wire logic [2:0]  csr_paddr,
   input  wire logic [31:0] csr_pwdata,
   output logic [31:0]      csr_prdata,
   output logic             csr_pready,
   output cfg_type          cfg
);

   logic [LEN_BITS-1:0] total_length_ff, total_length_in;
   logic [DIM_BITS-1:0] max_dimension_ff, max_dimension_in;
   logic                wr_en;

   assign csr_pready = 1'b1;
   assign wr_en      = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      total_length_in  = total_length_ff;
      max_dimension_in = max_dimension_ff;
      if (wr_en) begin
         case (csr_paddr[2])
            REG_TOTAL_LENGTH:  total_length_in  = csr_pwdata[LEN_BITS-1:0];
            REG_MAX_DIMENSION: max_dimension_in = csr_pwdata[DIM_BITS-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_length_ff  <= TOTAL_LENGTH_RST;
         max_dimension_ff <= MAX_DIMENSION_RST;
      end else begin
         total_length_ff  <= total_length_in;
         max_dimension_ff <= max_dimension_in;
      end
   end

   // misaligned reads return zero
   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[1:0] == 2'b00) begin
         case (csr_paddr[2])
            REG_TOTAL_LENGTH:  csr_prdata = {{(32-LEN_BITS){1'b0}}, total_length_ff};
            REG_MAX_DIMENSION: csr_prdata = {{(32-DIM_BITS){1'b0}}, max_dimension_ff};
            default:           csr_prdata = '0;
         endcase
      end
   end

   assign cfg.total_length  = total_length_ff;
   assign cfg.max_dimension = max_dimension_ff;

endmodule
`default_nettype wire

/* src/jbhp_parse.sv */
// Per-byte header parse: phase register, counters and verdict logic.
`default_nettype none
module jbhp_parse
   import jbhp_pkg::*;
(
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       byte_en,
   input  wire logic [7:0] data_byte,
   input  wire logic       first_byte,
   input  wire cfg_type    cfg,
   output verdict_type     verdict
);

   localparam logic [3:0] PH_IDLE   = 4'd0;
   localparam logic [3:0] PH_SOI1   = 4'd1;
   localparam logic [3:0] PH_SOI2   = 4'd2;
   localparam logic [3:0] PH_MARKER = 4'd3;
   localparam logic [3:0] PH_LEN_HI = 4'd4;
   localparam logic [3:0] PH_LEN_LO = 4'd5;
   localparam logic [3:0] PH_SKIP   = 4'd6;
   localparam logic [3:0] PH_PREC   = 4'd7;
   localparam logic [3:0] PH_H_HI   = 4'd8;
   localparam logic [3:0] PH_H_LO   = 4'd9;
   localparam logic [3:0] PH_W_HI   = 4'd10;
   localparam logic [3:0] PH_W_LO   = 4'd11;
   localparam logic [3:0] PH_COMP   = 4'd12;
   localparam logic [3:0] PH_DONE   = 4'd13;

   logic [3:0]          phase_ff, phase_in;
   logic [POS_BITS-1:0] pos_ff, pos_in;
   logic [7:0]          marker_ff, marker_in;
   logic [7:0]          len_hi_ff, len_hi_in;
   logic [15:0]         skip_ff, skip_in;
   logic [DIM_BITS-1:0] height_ff, height_in;
   logic [DIM_BITS-1:0] width_ff, width_in;

   logic [3:0]          cur_phase;
   logic [POS_BITS-1:0] idx;
   logic                active;
   logic [15:0]         seg_size;
   logic [15:0]         skip_dec;
   logic [SUM_BITS-1:0] seg_end;
   logic [SUM_BITS-1:0] file_lim;
   logic [SUM_BITS-1:0] next_pos_w;
   logic                is_frame;
   logic                hit;
   logic [STAT_BITS-1:0] st;

   assign cur_phase  = first_byte ? PH_SOI1 : phase_ff;
   assign idx        = first_byte ? '0 : pos_ff;
   assign active     = byte_en && (first_byte || (phase_ff != PH_IDLE && phase_ff < PH_DONE));
   assign seg_size   = {len_hi_ff, data_byte};
   assign skip_dec   = skip_ff - 16'd1;
   assign seg_end    = SUM_BITS'(idx) + SUM_BITS'(seg_size);
   assign file_lim   = SUM_BITS'(cfg.total_length) + SUM_BITS'(1);
   assign next_pos_w = SUM_BITS'(idx) + SUM_BITS'(1);
   assign is_frame   = (marker_ff inside {[MK_SOF0:MK_SOF15]}) &&
                       !(marker_ff inside {MK_DHT, MK_JPG, MK_DAC});

   always_comb begin
      phase_in  = phase_ff;
      pos_in    = pos_ff;
      marker_in = marker_ff;
      len_hi_in = len_hi_ff;
      skip_in   = skip_ff;
      height_in = height_ff;
      width_in  = width_ff;
      hit       = 1'b0;
      st        = ST_OK;

      if (active) begin
         phase_in = cur_phase;
         case (cur_phase)
            PH_SOI1: begin
               if (cfg.total_length < LEN_BITS'(4) || data_byte != MK_FILL) begin
                  hit = 1'b1;
                  st  = ST_NO_SOI;
               end else begin
                  phase_in = PH_SOI2;
               end
            end
            PH_SOI2: begin
               if (data_byte != MK_SOI) begin
                  hit = 1'b1;
                  st  = ST_NO_SOI;
               end else begin
                  phase_in = PH_MARKER;
               end
            end
            PH_MARKER: begin
               if (data_byte != MK_FILL) begin
                  marker_in = data_byte;
                  if (data_byte inside {MK_EOI, MK_SOS}) begin
                     hit = 1'b1;
                     st  = ST_END_SCAN;
                  end else if (!(data_byte inside {MK_TEM, [MK_RST0:MK_RST7]})) begin
                     phase_in = PH_LEN_HI;
                  end
               end
            end
            PH_LEN_HI: begin
               len_hi_in = data_byte;
               phase_in  = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               if (seg_size < 16'd2 || seg_end > file_lim) begin
                  hit = 1'b1;
                  st  = ST_BAD_LEN;
               end else if (is_frame) begin
                  if (marker_ff != MK_SOF0 || seg_size < 16'd8) begin
                     hit = 1'b1;
                     st  = ST_UNSUP;
                  end else begin
                     phase_in = PH_PREC;
                  end
               end else begin
                  skip_in  = seg_size - 16'd2;
                  phase_in = (seg_size != 16'd2) ? PH_SKIP : PH_MARKER;
               end
            end
            PH_SKIP: begin
               skip_in = skip_dec;
               if (skip_dec == 16'd0) begin
                  phase_in = PH_MARKER;
               end
            end
            PH_PREC: begin
               if (data_byte != PRECISION) begin
                  hit = 1'b1;
                  st  = ST_UNSUP;
               end else begin
                  phase_in = PH_H_HI;
               end
            end
            PH_H_HI: begin
               height_in = {data_byte, 8'h00};
               phase_in  = PH_H_LO;
            end
            PH_H_LO: begin
               height_in = {height_ff[15:8], data_byte};
               phase_in  = PH_W_HI;
            end
            PH_W_HI: begin
               width_in = {data_byte, 8'h00};
               phase_in = PH_W_LO;
            end
            PH_W_LO: begin
               width_in = {width_ff[15:8], data_byte};
               phase_in = PH_COMP;
            end
            PH_COMP: begin
               hit = 1'b1;
               if (width_ff == '0 || height_ff == '0 ||
                   width_ff > cfg.max_dimension || height_ff > cfg.max_dimension ||
                   !(data_byte inside {COMPS_GRAY, COMPS_COLOR})) begin
                  st = ST_BAD_SIZE;
               end else begin
                  st = ST_OK;
               end
            end
            default: ;
         endcase

         if (!hit && next_pos_w == SUM_BITS'(cfg.total_length)) begin
            hit = 1'b1;
            st  = ST_DATA_END;
         end
         pos_in = next_pos_w[POS_BITS-1:0];
         if (hit) begin
            phase_in = PH_DONE;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         pos_ff    <= '0;
         marker_ff <= '0;
         len_hi_ff <= '0;
         skip_ff   <= '0;
         height_ff <= '0;
         width_ff  <= '0;
      end else begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         marker_ff <= marker_in;
         len_hi_ff <= len_hi_in;
         skip_ff   <= skip_in;
         height_ff <= height_in;
         width_ff  <= width_in;
      end
   end

   assign verdict.valid             = hit;
   assign verdict.item.status       = st;
   assign verdict.item.image_width  = (st == ST_OK) ? width_ff : '0;
   assign verdict.item.image_height = (st == ST_OK) ? height_ff : '0;

   // a verdict always parks the parser until the next start of file
   a_done_after_verdict: assert property (@(posedge clock) disable iff (reset)
      verdict.valid |=> phase_ff == PH_DONE)
      else $error("parser not parked after verdict");

   a_ok_has_size: assert property (@(posedge clock) disable iff (reset)
      verdict.valid && verdict.item.status == ST_OK |->
         verdict.item.image_width != '0 && verdict.item.image_height != '0)
      else $error("ok verdict with zero dimension");

   a_idle_no_verdict: assert property (@(posedge clock) disable iff (reset)
      !byte_en |-> !verdict.valid)
      else $error("verdict without a byte");

endmodule
`default_nettype wire

/* src/jbhp_rsp_queue.sv */
// Two-entry result queue: output register plus skid entry.
`default_nettype none
module jbhp_rsp_queue
   import jbhp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire verdict_type               verdict,
   output logic                           room,
   output logic                           rsp_tvalid,
   input  wire logic                      rsp_tready,
   output logic [RSP_TDATA_BITS-1:0]      rsp_tdata
);

   rsp_item_type head_ff, head_in;
   rsp_item_type tail_ff, tail_in;
   logic [1:0]   count_ff, count_in;
   logic         push, pop;

   assign push       = verdict.valid;
   assign pop        = rsp_tvalid && rsp_tready;
   assign rsp_tvalid = (count_ff != 2'd0);
   assign room       = (count_ff != 2'd2);
   assign rsp_tdata  = {{(RSP_TDATA_BITS-RSP_BITS){1'b0}},
                        head_ff.image_height, head_ff.image_width, head_ff.status};

   always_comb begin
      head_in  = head_ff;
      tail_in  = tail_ff;
      count_in = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) begin
               head_in = verdict.item;
            end else begin
               tail_in = verdict.item;
            end
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            head_in  = tail_ff;
            count_in = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               head_in = verdict.item;
            end else begin
               head_in = tail_ff;
               tail_in = verdict.item;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
      head_ff <= head_in;
      tail_ff <= tail_in;
   end

   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      !(push && !pop && count_ff == 2'd2))
      else $error("result queue overflow");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("result queue count out of range");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> rsp_tvalid)
      else $error("pushed result not presented");

endmodule
`default_nettype wire

/* src/jpeg_baseline_header_parser.sv */
// Top level of the JPEG baseline header parser.
// The block takes a JPEG file one byte per transfer on the req_ side (tdata is the byte,
// tuser marks byte zero of a new file) and gives at most one verdict per file on the
// rsp_ side: status 0 with the frame width and height for an accepted baseline C0
// frame, otherwise an error code and zero dimensions. It sustains one byte per clock:
// each byte updates the phase register and counters, and any verdict lands in a
// two-entry result queue, so input keeps flowing while a verdict waits to be taken;
// req_tready drops only while both queue entries are held. With the queue empty a
// verdict appears on rsp_ in the cycle after the byte that caused it; behind a waiting
// verdict it follows once that one is taken. The file length (register 0, byte
// address 0) and the largest accepted dimension (register 1, byte address 4) must be
// written over the csr_ port only while no file is being parsed (not enforced).
// Bytes before the first start-of-file and after a verdict are taken and dropped.
`default_nettype none
module jpeg_baseline_header_parser
   import jbhp_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   // byte input
   input  wire logic                 req_tvalid,
   output logic                      req_tready,
   input  wire logic [7:0]           req_tdata,   // [7:0] data_byte
   input  wire logic                 req_tuser,   // [0] first_byte
   // verdict output
   output logic                      rsp_tvalid,
   input  wire logic                 rsp_tready,
   output logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // [2:0] status, [18:3] image_width,
                                                  // [34:19] image_height, rest zero
   // configuration
   input  wire logic                 csr_psel,
   input  wire logic                 csr_penable,
   input  wire logic                 csr_pwrite,
   input  wire logic [2:0]           csr_paddr,
   input  wire logic [31:0]          csr_pwdata,
   output logic [31:0]               csr_prdata,
   output logic                      csr_pready
);

   cfg_type     cfg;
   verdict_type verdict;
   logic        room;
   logic        byte_en;

   // req_tready is high whenever the queue can take a possible verdict
   assign req_tready = room;
   assign byte_en    = req_tvalid && req_tready;

   jbhp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .cfg         (cfg)
   );

   jbhp_parse u_parse (
      .clock      (clock),
      .reset      (reset),
      .byte_en    (byte_en),
      .data_byte  (req_tdata),
      .first_byte (req_tuser),
      .cfg        (cfg),
      .verdict    (verdict)
   );

   jbhp_rsp_queue u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .verdict    (verdict),
      .room       (room),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
`default_nettype wire

/* tb/sv/jbhp_verdict_checker.sv */
// Verdict predictor and scoreboard for the JPEG baseline header parser.
`timescale 1ns / 1ps
module jbhp_verdict_checker
   import jbhp_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_tvalid,
   input  wire logic                      req_tready,
   input  wire logic [7:0]                req_tdata,   // [7:0] data_byte
   input  wire logic                      req_tuser,   // [0] first_byte
   input  wire logic                      rsp_tvalid,
   input  wire logic                      rsp_tready,
   input  wire logic [RSP_TDATA_BITS-1:0] rsp_tdata,   // [2:0] status, [18:3] width,
                                                       // [34:19] height
   input  wire logic                      csr_psel,
   input  wire logic                      csr_penable,
   input  wire logic                      csr_pwrite,
   input  wire logic [2:0]                csr_paddr,
   input  wire logic [31:0]               csr_pwdata,
   input  wire logic                      csr_pready,
   output int                             fail_count,
   output int                             verdicts_pending
);

   typedef enum logic [3:0] {
      PARSE_IDLE, SOI_FF, SOI_D8, SEG_MARKER, LEN_HIGH, LEN_LOW, SEG_SKIP,
      FRAME_PREC, HEIGHT_HIGH, HEIGHT_LOW, WIDTH_HIGH, WIDTH_LOW, FRAME_COMP, PARSE_DONE
   } parse_phase_type;

   cfg_type             cfg;
   parse_phase_type     phase;
   logic [POS_BITS-1:0] pos;
   logic [7:0]          marker;
   logic [7:0]          len_hi;
   logic [15:0]         skip_left;
   logic [15:0]         height;
   logic [15:0]         width;
   rsp_item_type        verdict_q[$];

   // start-of-frame family, minus DHT, JPG and DAC
   function automatic bit is_sof(input logic [7:0] m);
      return m >= MK_SOF0 && m <= MK_SOF15 && m != MK_DHT && m != MK_JPG && m != MK_DAC;
   endfunction

   task automatic parse_byte(input logic [7:0] b, input logic first);
      longint unsigned idx;
      longint unsigned seg_len;
      longint unsigned file_len;
      bit              decided;
      logic [2:0]      st;
      rsp_item_type    v;
      decided = 1'b0;
      st = ST_OK;
      if (first) begin
         pos = '0;
         phase = SOI_FF;
      end else if (phase == PARSE_IDLE || phase == PARSE_DONE) begin
         return;
      end
      idx = pos;
      file_len = cfg.total_length;

      case (phase)
         SOI_FF: begin
            if (cfg.total_length < 4 || b != MK_FILL) begin
               decided = 1'b1;
               st = ST_NO_SOI;
            end else begin
               phase = SOI_D8;
            end
         end
         SOI_D8: begin
            if (b != MK_SOI) begin
               decided = 1'b1;
               st = ST_NO_SOI;
            end else begin
               phase = SEG_MARKER;
            end
         end
         SEG_MARKER: begin
            // fill bytes are skipped, anything else is the marker itself
            if (b != MK_FILL) begin
               marker = b;
               if (b == MK_EOI || b == MK_SOS) begin
                  decided = 1'b1;
                  st = ST_END_SCAN;
               end else if (!(b == MK_TEM || (b >= MK_RST0 && b <= MK_RST7))) begin
                  phase = LEN_HIGH;
               end
            end
         end
         LEN_HIGH: begin
            len_hi = b;
            phase = LEN_LOW;
         end
         LEN_LOW: begin
            seg_len = {len_hi, b};
            // segment began one byte back and must end inside the file
            if (seg_len < 2 || idx + seg_len > file_len + 1) begin
               decided = 1'b1;
               st = ST_BAD_LEN;
            end else if (is_sof(marker)) begin
               if (marker != MK_SOF0 || seg_len < 8) begin
                  decided = 1'b1;
                  st = ST_UNSUP;
               end else begin
                  phase = FRAME_PREC;
               end
            end else begin
               skip_left = 16'(seg_len - 2);
               phase = (skip_left != 0) ? SEG_SKIP : SEG_MARKER;
            end
         end
         SEG_SKIP: begin
            skip_left = skip_left - 16'd1;
            if (skip_left == 0) phase = SEG_MARKER;
         end
         FRAME_PREC: begin
            if (b != PRECISION) begin
               decided = 1'b1;
               st = ST_UNSUP;
            end else begin
               phase = HEIGHT_HIGH;
            end
         end
         HEIGHT_HIGH: begin
            height = {b, 8'h00};
            phase = HEIGHT_LOW;
         end
         HEIGHT_LOW: begin
            height[7:0] = b;
            phase = WIDTH_HIGH;
         end
         WIDTH_HIGH: begin
            width = {b, 8'h00};
            phase = WIDTH_LOW;
         end
         WIDTH_LOW: begin
            width[7:0] = b;
            phase = FRAME_COMP;
         end
         FRAME_COMP: begin
            decided = 1'b1;
            if (width == 0 || height == 0 || width > cfg.max_dimension ||
                height > cfg.max_dimension || (b != COMPS_GRAY && b != COMPS_COLOR))
               st = ST_BAD_SIZE;
            else
               st = ST_OK;
         end
         default: return;
      endcase

      if (!decided && idx + 1 == file_len) begin
         decided = 1'b1;
         st = ST_DATA_END;
      end
      pos = pos + 1'b1;

      if (decided) begin
         phase = PARSE_DONE;
         v.status = st;
         v.image_width = (st == ST_OK) ? width : 16'd0;
         v.image_height = (st == ST_OK) ? height : 16'd0;
         verdict_q.push_back(v);
      end
   endtask

   task automatic check_verdict(input logic [RSP_TDATA_BITS-1:0] beat);
      rsp_item_type got;
      rsp_item_type want;
      got.status = beat[STAT_BITS-1:0];
      got.image_width = beat[STAT_BITS +: DIM_BITS];
      got.image_height = beat[STAT_BITS+DIM_BITS +: DIM_BITS];
      if (verdict_q.size() == 0) begin
         $display("%0t: verdict with none expected: status %0d width %0d height %0d",
                  $time, got.status, got.image_width, got.image_height);
         fail_count++;
         return;
      end
      want = verdict_q.pop_front();
      if (got.status !== want.status) begin
         $display("%0t: status expected %0d, actual %0d", $time, want.status, got.status);
         fail_count++;
      end
      if (got.image_width !== want.image_width) begin
         $display("%0t: image_width expected %0d, actual %0d",
                  $time, want.image_width, got.image_width);
         fail_count++;
      end
      if (got.image_height !== want.image_height) begin
         $display("%0t: image_height expected %0d, actual %0d",
                  $time, want.image_height, got.image_height);
         fail_count++;
      end
   endtask

   // byte first, then verdict, then register write: a write lands after the edge
   always @(posedge clock) begin
      if (reset) begin
         cfg.total_length = TOTAL_LENGTH_RST;
         cfg.max_dimension = MAX_DIMENSION_RST;
         phase = PARSE_IDLE;
         pos = '0;
         marker = '0;
         len_hi = '0;
         skip_left = '0;
         height = '0;
         width = '0;
         verdict_q.delete();
         fail_count = 0;
      end else begin
         if (req_tvalid && req_tready) parse_byte(req_tdata, req_tuser);
         if (rsp_tvalid && rsp_tready) check_verdict(rsp_tdata);
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            if (csr_paddr[2] == REG_TOTAL_LENGTH)
               cfg.total_length = csr_pwdata[LEN_BITS-1:0];
            else
               cfg.max_dimension = csr_pwdata[DIM_BITS-1:0];
         end
      end
      verdicts_pending = verdict_q.size();
   end

endmodule

/* tb/sv/jpeg_baseline_header_parser_test.sv */
// Stimulus and verdict for the JPEG baseline header parser testbench.
`timescale 1ns / 1ps
module jpeg_baseline_header_parser_test;
   import jbhp_pkg::*;

   // register byte addresses
   localparam logic [2:0] ADDR_TOTAL_LENGTH  = {REG_TOTAL_LENGTH, 2'b00};
   localparam logic [2:0] ADDR_MAX_DIMENSION = {REG_MAX_DIMENSION, 2'b00};

   // segment markers used only to build files
   localparam logic [7:0] MK_DQT  = 8'hDB;
   localparam logic [7:0] MK_DRI  = 8'hDD;
   localparam logic [7:0] MK_APP0 = 8'hE0;
   localparam logic [7:0] MK_COM  = 8'hFE;

   localparam logic [31:0] LEN_MAX = 32'(2 ** LEN_BITS - 1);
   localparam logic [15:0] DIM_MAX = 16'hFFFF;

   localparam int ITEM_TARGET = 1150;  // bytes to push before wrapping up
   localparam int MAX_GAP     = 13;    // longest idle per transfer on either side
   localparam int SETTLE      = 4;     // settle wait; a verdict lands in the cycle after its byte
   localparam int DRAIN       = 8;     // tail wait after the last expected verdict
   localparam int STALL_LIMIT = 400;   // cycles without any transfer before giving up

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [7:0]                req_tdata = '0;
   logic                      req_tuser = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [RSP_TDATA_BITS-1:0] rsp_tdata;
   logic                      csr_psel = 1'b0;
   logic                      csr_penable = 1'b0;
   logic                      csr_pwrite = 1'b0;
   logic [2:0]                csr_paddr = '0;
   logic [31:0]               csr_pwdata = '0;
   logic [31:0]               csr_prdata;
   logic                      csr_pready;

   int fail_count;
   int verdicts_pending;

   // transfer flags latched at the rising edge, read by the negedge drivers
   logic req_took = 1'b0;
   logic rsp_took = 1'b0;
   bit   calm = 1'b0;       // no idling on either side while set
   int   rsp_hold = 0;
   int   quiet_cycles = 0;
   int   bytes_sent = 0;

   logic [7:0]  file_bytes[$];
   logic [15:0] cur_max_dim = MAX_DIMENSION_RST;

   always #5 clock = ~clock;

   jpeg_baseline_header_parser u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   jbhp_verdict_checker u_checker (
      .clock            (clock),
      .reset            (reset),
      .req_tvalid       (req_tvalid),
      .req_tready       (req_tready),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .rsp_tvalid       (rsp_tvalid),
      .rsp_tready       (rsp_tready),
      .rsp_tdata        (rsp_tdata),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_pready       (csr_pready),
      .fail_count       (fail_count),
      .verdicts_pending (verdicts_pending)
   );

   always @(posedge clock) begin
      req_took <= req_tvalid && req_tready;
      rsp_took <= rsp_tvalid && rsp_tready;
   end

   // Result side: after each verdict transfer, hold tready low for a fresh
   // random count; the count runs down whether or not a verdict is waiting,
   // so stalls land on every phase of the output queue.
   always @(negedge clock) begin
      if (rsp_took) rsp_hold = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (rsp_hold > 0) begin
         rsp_tready <= 1'b0;
         rsp_hold--;
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   // Watchdog: any transfer on any channel restarts the count.
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready) ||
          (csr_psel && csr_penable && csr_pwrite && csr_pready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   // One byte transfer. Called and returns at a falling edge. A zero gap keeps
   // tvalid high straight into the next byte.
   task automatic push_byte(input logic [7:0] data, input logic first);
      int gap;
      gap = calm ? 0 : $urandom_range(0, MAX_GAP);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= data;
      req_tuser <= first;
      do @(negedge clock); while (!req_took);
      bytes_sent++;
   endtask

   task automatic send_file(input int count);
      for (int i = 0; i < count; i++) push_byte(file_bytes[i], i == 0);
   endtask

   // Drop tvalid, let every expected verdict drain, then give trailing
   // ignored bytes time to pass through before touching a register.
   task automatic quiesce();
      req_tvalid <= 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
      repeat (SETTLE) @(negedge clock);
   endtask

   // setup and access phases, then psel drops before the task returns, so back-to-back
   // writes never assign psel twice in one step
   task automatic csr_write(input logic [2:0] addr, input logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= addr;
      csr_pwdata <= data;
      @(negedge clock);
      csr_penable <= 1'b1;
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      @(negedge clock);
   endtask

   // width/height: zero, one, at and just past the limit, full range, in range
   function automatic logic [15:0] pick_dim(input logic [15:0] limit);
      case ($urandom_range(0, 9))
         0: return 16'd0;
         1: return 16'd1;
         2: return limit;
         3: return limit + 16'd1;
         4: return 16'($urandom);
         default: return 16'($urandom_range(1, limit));
      endcase
   endfunction

   function automatic logic [15:0] pick_max_dim();
      case ($urandom_range(0, 5))
         0: return 16'd1;
         1: return DIM_MAX;
         2: return MAX_DIMENSION_RST;
         3: return 16'($urandom_range(1, 64));
         default: return 16'($urandom_range(1, 65535));
      endcase
   endfunction

   // mostly the real length, sometimes short, long, tiny or the largest value
   function automatic logic [31:0] pick_total(input int size);
      case ($urandom_range(0, 19))
         0: return LEN_MAX;
         1: return 32'($urandom_range(0, 3));
         2, 3: return 32'($urandom_range(0, size));
         4, 5: return 32'(size + $urandom_range(1, 20));
         default: return 32'(size);
      endcase
   endfunction

   function automatic logic [7:0] pick_plain_marker();
      case ($urandom_range(0, 7))
         0: return MK_DHT;
         1: return MK_JPG;
         2: return MK_DAC;
         3: return MK_DQT;
         4: return MK_DRI;
         5: return MK_APP0 + 8'($urandom_range(0, 15));
         6: return MK_COM;
         default: return 8'($urandom);
      endcase
   endfunction

   // frame markers other than baseline: rejected as unsupported
   function automatic logic [7:0] pick_other_sof();
      logic [7:0] m;
      do m = MK_SOF0 + 8'($urandom_range(1, 15));
      while (m == MK_DHT || m == MK_JPG || m == MK_DAC);
      return m;
   endfunction

   // usually one FF before a marker; sometimes none, or a run of fill
   task automatic put_fill();
      int fills;
      fills = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 3) : 1;
      repeat (fills) file_bytes.push_back(MK_FILL);
   endtask

   // Mostly well-formed: SOI, a few skipped segments, one frame header, a
   // short tail that follows the verdict. Some files are pure noise and
   // some carry one corrupted byte.
   task automatic build_file(input logic [15:0] dim_limit);
      int          segs;
      int          seg_len;
      int          comps;
      logic [15:0] flen;
      logic [15:0] h;
      logic [15:0] w;
      logic [7:0]  mk;
      file_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
         repeat ($urandom_range(1, 12)) file_bytes.push_back(8'($urandom));
         return;
      end
      file_bytes.push_back(MK_FILL);
      file_bytes.push_back(MK_SOI);

      segs = $urandom_range(0, 3);
      repeat (segs) begin
         put_fill();
         if ($urandom_range(0, 3) == 0) begin
            // bare marker, no length
            if ($urandom_range(0, 8) == 8)
               file_bytes.push_back(MK_TEM);
            else
               file_bytes.push_back(MK_RST0 + 8'($urandom_range(0, 7)));
         end else begin
            file_bytes.push_back(pick_plain_marker());
            seg_len = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 1) : $urandom_range(2, 8);
            file_bytes.push_back(8'h00);
            file_bytes.push_back(8'(seg_len));
            if (seg_len > 2) repeat (seg_len - 2) file_bytes.push_back(8'($urandom));
         end
      end

      put_fill();
      case ($urandom_range(0, 19))
         0, 1: mk = pick_other_sof();
         2: mk = MK_EOI;
         3: mk = MK_SOS;
         default: mk = MK_SOF0;
      endcase
      file_bytes.push_back(mk);

      if ($urandom_range(0, 9) == 0)
         comps = $urandom_range(0, 255);
      else
         comps = ($urandom_range(0, 1) == 0) ? COMPS_GRAY : COMPS_COLOR;
      flen = 16'(8 + 3 * ((comps == COMPS_GRAY) ? COMPS_GRAY : COMPS_COLOR));
      if ($urandom_range(0, 9) == 0)
         flen = ($urandom_range(0, 1) == 0) ? 16'($urandom_range(0, 9)) : 16'($urandom);
      file_bytes.push_back(flen[15:8]);
      file_bytes.push_back(flen[7:0]);
      file_bytes.push_back(($urandom_range(0, 9) == 0) ? 8'($urandom) : PRECISION);
      h = pick_dim(dim_limit);
      w = pick_dim(dim_limit);
      file_bytes.push_back(h[15:8]);
      file_bytes.push_back(h[7:0]);
      file_bytes.push_back(w[15:8]);
      file_bytes.push_back(w[7:0]);
      file_bytes.push_back(8'(comps));
      // component specs, then a tail that the block must drop
      repeat ((comps == COMPS_GRAY) ? 3 : 9) file_bytes.push_back(8'($urandom));
      repeat ($urandom_range(0, 3)) file_bytes.push_back(8'($urandom));

      if ($urandom_range(0, 9) == 0)
         file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
   endtask

   initial begin : stimulus
      int          count;
      bit          cut;
      bit          prev_cut;
      logic [15:0] next_max;
      prev_cut = 1'b0;

      repeat (6) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // ---- directed ----
      // bytes before any start-of-file are dropped
      push_byte(8'($urandom), 1'b0);
      push_byte(8'($urandom), 1'b0);

      // zero file length: rejected on byte zero
      quiesce();
      csr_write(ADDR_TOTAL_LENGTH, '0);
      file_bytes = '{MK_FILL};
      send_file(file_bytes.size());

      // largest file length, end-of-image right after SOI
      quiesce();
      csr_write(ADDR_TOTAL_LENGTH, LEN_MAX);
      file_bytes = '{MK_FILL, MK_SOI, MK_EOI};
      send_file(file_bytes.size());

      // shortest legal frame, no fill before SOF0, widest image at the top limit
      quiesce();
      csr_write(ADDR_MAX_DIMENSION, 32'(DIM_MAX));
      cur_max_dim = DIM_MAX;
      file_bytes = '{MK_FILL, MK_SOI, MK_SOF0, 8'h00, 8'h08, PRECISION,
                     8'hFF, 8'hFF, 8'hFF, 8'hFF, COMPS_COLOR};
      csr_write(ADDR_TOTAL_LENGTH, 32'(file_bytes.size()));
      send_file(file_bytes.size());

      // ---- random files ----
      // A cut-off file is followed by the next one with no register write in
      // between, so its first byte restarts a parse that may still be running.
      while (bytes_sent < ITEM_TARGET) begin
         calm = ($urandom_range(0, 4) == 0);
         next_max = cur_max_dim;
         if (!prev_cut && $urandom_range(0, 3) == 0) next_max = pick_max_dim();
         build_file(next_max);
         if (!prev_cut) begin
            quiesce();
            if (next_max != cur_max_dim || $urandom_range(0, 7) == 0) begin
               csr_write(ADDR_MAX_DIMENSION, 32'(next_max));
               cur_max_dim = next_max;
            end
            csr_write(ADDR_TOTAL_LENGTH, pick_total(file_bytes.size()));
         end
         cut = ($urandom_range(0, 6) == 0);
         count = cut ? $urandom_range(1, file_bytes.size()) : file_bytes.size();
         send_file(count);
         prev_cut = cut;
      end

      // ---- wrap up ----
      req_tvalid <= 1'b0;
      while (verdicts_pending != 0) @(negedge clock);
      repeat (DRAIN) @(negedge clock);
      if (fail_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule
